### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/met_pkg.sv
package met_pkg;

   localparam int PIXEL_W   = 10;
   localparam int COORD_W   = 13;
   localparam int Q_W       = 32;
   localparam int STEP_W    = 31;
   localparam int ITER_W    = 12;
   localparam int COUNT_W   = 13;
   localparam int FRAC_BITS = 28;
   localparam int PROD_W    = PIXEL_W + STEP_W;
   localparam int SAT_W     = 44;
   localparam int MUL_W     = 2 * Q_W;
   localparam int SQ_W      = MUL_W - FRAC_BITS;
   localparam int CROSS_W   = MUL_W - FRAC_BITS + 1;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam int IMAGE_WIDTH_DEF  = 1024;
   localparam int IMAGE_HEIGHT_DEF = 1024;
   localparam int ITER_LIMIT_DEF   = 4095;
   localparam int QUEUE_DEPTH_DEF  = 2;

   localparam logic signed [Q_W-1:0] MIN_RE_RST  = -32'sd536870912;
   localparam logic signed [Q_W-1:0] MAX_IM_RST  = 32'sd536870912;
   localparam logic [STEP_W-1:0]     STEP_RST    = 31'd1049601;
   localparam logic [ITER_W-1:0]     MAX_ITER_RST = 12'd64;

   // 4.0 in q4.28, at the width of the magnitude sum
   localparam logic signed [SQ_W:0] ESCAPE_BOUND = (SQ_W + 1)'(64'sd1073741824);

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'sh7FFF_FFFF);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'($signed(32'h8000_0000));

   typedef enum logic [2:0] {
      REG_MIN_RE   = 3'd0,
      REG_MAX_IM   = 3'd1,
      REG_STEP_RE  = 3'd2,
      REG_STEP_IM  = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [Q_W-1:0] min_re;
      logic signed [Q_W-1:0] max_im;
      logic [STEP_W-1:0]     step_re;
      logic [STEP_W-1:0]     step_im;
      logic [ITER_W-1:0]     loop_limit;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]    px;
      logic [PIXEL_W-1:0]    py;
      logic signed [Q_W-1:0] cr;
      logic signed [Q_W-1:0] ci;
      logic [ITER_W-1:0]     limit;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[Q_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/met_req_if.sv
interface met_req_if;
   import met_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_x;
   logic [PIXEL_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### rtl/met_rsp_if.sv
interface met_rsp_if;
   import met_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_x;
   logic [PIXEL_W-1:0] out_y;
   logic [COUNT_W-1:0] iteration_count;

   modport source (output valid, output out_x, output out_y, output iteration_count,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input iteration_count,
                 output ready);
endinterface

### rtl/met_csr.sv
module met_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [met_pkg::ADDR_W-1:0]     paddr,
   input  logic [met_pkg::DATA_W-1:0]     pwdata,
   output logic [met_pkg::DATA_W-1:0]     prdata,
   output logic                           pready,
   output met_pkg::cfg_type               cfg
);
   import met_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MIN_RE:   cfg_in.min_re     = pwdata;
            REG_MAX_IM:   cfg_in.max_im     = pwdata;
            REG_STEP_RE:  cfg_in.step_re    = pwdata[STEP_W-1:0];
            REG_STEP_IM:  cfg_in.step_im    = pwdata[STEP_W-1:0];
            REG_MAX_ITER: cfg_in.loop_limit = pwdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_RE:   prdata = cfg_ff.min_re;
         REG_MAX_IM:   prdata = cfg_ff.max_im;
         REG_STEP_RE:  prdata = {1'b0, cfg_ff.step_re};
         REG_STEP_IM:  prdata = {1'b0, cfg_ff.step_im};
         REG_MAX_ITER: prdata = {{(DATA_W-ITER_W){1'b0}}, cfg_ff.loop_limit};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_re     <= MIN_RE_RST;
         cfg_ff.max_im     <= MAX_IM_RST;
         cfg_ff.step_re    <= STEP_RST;
         cfg_ff.step_im    <= STEP_RST;
         cfg_ff.loop_limit <= MAX_ITER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

### rtl/met_front.sv
module met_front #(
   parameter int IMAGE_WIDTH  = met_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = met_pkg::IMAGE_HEIGHT_DEF,
   parameter int ITER_LIMIT   = met_pkg::ITER_LIMIT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   met_req_if.sink                 req_chan,
   input  met_pkg::cfg_type        cfg,
   input  met_pkg::fifo_stat_type  stat,
   output logic                    push,
   output met_pkg::job_type        job
);
   import met_pkg::*;

   localparam logic [COORD_W-1:0] X_LAST   = COORD_W'(IMAGE_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_LAST   = COORD_W'(IMAGE_HEIGHT - 1);
   localparam logic [16:0]        ITER_CAP = 17'(ITER_LIMIT);

   logic                 s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [PROD_W-1:0]    pre_ff, pre_in, pim_ff, pim_in;
   logic [ITER_W-1:0]    limit_ff, limit_in;
   logic [PIXEL_W-1:0]   x_clamp, y_clamp;
   logic                 accept;
   logic signed [SAT_W-1:0] cr_wide, ci_wide;

   assign req_chan.ready = !s1_valid_ff || !stat.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = s1_valid_ff && !stat.full;

   // pixels past the image edge map to the last column or row
   always_comb begin
      x_clamp = req_chan.pixel_x;
      y_clamp = req_chan.pixel_y;
      if ({(COORD_W-PIXEL_W)'(0), req_chan.pixel_x} > X_LAST) begin
         x_clamp = X_LAST[PIXEL_W-1:0];
      end
      if ({(COORD_W-PIXEL_W)'(0), req_chan.pixel_y} > Y_LAST) begin
         y_clamp = Y_LAST[PIXEL_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      pre_in      = pre_ff;
      pim_in      = pim_ff;
      limit_in    = limit_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         px_in       = req_chan.pixel_x;
         py_in       = req_chan.pixel_y;
         pre_in      = PROD_W'(x_clamp) * PROD_W'(cfg.step_re);
         pim_in      = PROD_W'(y_clamp) * PROD_W'(cfg.step_im);
         limit_in    = cfg.loop_limit;
         if ({5'b0, cfg.loop_limit} > ITER_CAP) begin
            limit_in = ITER_CAP[ITER_W-1:0];
         end
      end
   end

   // point mapping, saturated to q4.28
   assign cr_wide = {{(SAT_W-Q_W){cfg.min_re[Q_W-1]}}, cfg.min_re}
                  + {{(SAT_W-PROD_W){1'b0}}, pre_ff};
   assign ci_wide = {{(SAT_W-Q_W){cfg.max_im[Q_W-1]}}, cfg.max_im}
                  - {{(SAT_W-PROD_W){1'b0}}, pim_ff};

   assign job.px    = px_ff;
   assign job.py    = py_ff;
   assign job.cr    = sat_q(cr_wide);
   assign job.ci    = sat_q(ci_wide);
   assign job.limit = limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      pre_ff   <= pre_in;
      pim_ff   <= pim_in;
      limit_ff <= limit_in;
   end
endmodule

### rtl/met_fifo.sv
module met_fifo #(
   parameter int DEPTH = met_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  met_pkg::job_type              wr_data,
   input  logic                          pop,
   output met_pkg::job_type              rd_data,
   output met_pkg::fifo_stat_type        stat,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import met_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign rd_data    = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

### rtl/met_core.sv
module met_core (
   input  logic                    clock,
   input  logic                    reset,
   input  met_pkg::job_type        job,
   input  met_pkg::fifo_stat_type  stat,
   output logic                    pop,
   met_rsp_if.source               rsp_chan
);
   import met_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_HOLD
   } state_type;

   state_type               state_ff, state_in;
   logic signed [Q_W-1:0]   zr_ff, zr_in, zi_ff, zi_in, cr_ff, cr_in, ci_ff, ci_in;
   logic signed [MUL_W-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [ITER_W-1:0]       limit_ff, limit_in;
   logic [PIXEL_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic signed [SQ_W-1:0]    zr2, zi2;
   logic signed [CROSS_W-1:0] cross_q;
   logic signed [SQ_W:0]      mag;
   logic signed [SAT_W-1:0]   zr_wide, zi_wide;
   logic                      finished, slot_free;

   // floored shifts of the registered products
   assign zr2     = rr_ff[MUL_W-1:FRAC_BITS];
   assign zi2     = ii_ff[MUL_W-1:FRAC_BITS];
   assign cross_q = ri_ff[MUL_W-1:FRAC_BITS-1];
   assign mag   = {zr2[SQ_W-1], zr2} + {zi2[SQ_W-1], zi2};
   assign finished = (mag > ESCAPE_BOUND) || (count_ff > {1'b0, limit_ff});

   assign zr_wide = {{(SAT_W-SQ_W){zr2[SQ_W-1]}}, zr2}
                  - {{(SAT_W-SQ_W){zi2[SQ_W-1]}}, zi2}
                  + {{(SAT_W-Q_W){cr_ff[Q_W-1]}}, cr_ff};
   assign zi_wide = {{(SAT_W-CROSS_W){cross_q[CROSS_W-1]}}, cross_q}
                  + {{(SAT_W-Q_W){ci_ff[Q_W-1]}}, ci_ff};

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = (state_ff == ST_IDLE) && !stat.empty;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_x           = rsp_x_ff;
   assign rsp_chan.out_y           = rsp_y_ff;
   assign rsp_chan.iteration_count = rsp_count_ff;

   always_comb begin
      state_in     = state_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!stat.empty) begin
               zr_in    = job.cr;
               zi_in    = job.ci;
               cr_in    = job.cr;
               ci_in    = job.ci;
               px_in    = job.px;
               py_in    = job.py;
               limit_in = job.limit;
               count_in = COUNT_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rr_in    = zr_ff * zr_ff;
            ii_in    = zi_ff * zi_ff;
            ri_in    = zr_ff * zi_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (finished) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = px_ff;
                  rsp_y_in     = py_ff;
                  rsp_count_in = count_ff;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               zr_in    = sat_q(zr_wide);
               zi_in    = sat_q(zi_wide);
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      ri_ff        <= ri_in;
      count_ff     <= count_in;
      limit_ff     <= limit_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_count_ff <= rsp_count_in;
   end
endmodule

### rtl/mandelbrot_escape_time_pixel.sv
// channel    dir   beat contents                         handshake
// req_chan   in    pixel_x, pixel_y                      valid / ready
// rsp_chan   out   out_x, out_y, iteration_count         valid / ready
// csr (apb)  in    min_re, max_im, step_re, step_im,     psel / penable, pready high
//                  loop_limit at byte 4*index
//
// front end: clamp and pitch multiply into a register, then point map into the queue
// each escape loop pass is a multiply, then a test and update; a pixel holds the
// iteration unit until it escapes or hits its limit, which sets the rate
// reset is synchronous and active high; it empties the queue and restores the registers
// a held result does not stop intake: the queue keeps accepting beats until it fills
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
   parameter int IMAGE_WIDTH  = met_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = met_pkg::IMAGE_HEIGHT_DEF,
   parameter int ITER_LIMIT   = met_pkg::ITER_LIMIT_DEF,
   parameter int QUEUE_DEPTH  = met_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   met_req_if.sink                     req_chan,
   met_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [met_pkg::ADDR_W-1:0]  paddr,
   input  logic [met_pkg::DATA_W-1:0]  pwdata,
   output logic [met_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import met_pkg::*;

   cfg_type                          cfg;
   fifo_stat_type                    fifo_stat;
   job_type                          push_job;
   job_type                          pop_job;
   logic                             push;
   logic                             pop;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;
   logic [COUNT_W-1:0]               count_ceiling;
   logic                             count_ok;

   // register file on the apb port
   met_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front end: clamp the pixel, map it to c, latch the effective limit
   met_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .ITER_LIMIT   (ITER_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .stat     (fifo_stat),
      .push     (push),
      .job      (push_job)
   );

   // short job queue decoupling the mapper from the iteration unit
   met_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_job),
      .pop     (pop),
      .rd_data (pop_job),
      .stat    (fifo_stat),
      .count   (queue_count)
   );

   // back end: escape loop and the output register
   met_core u_core (
      .clock    (clock),
      .reset    (reset),
      .job      (pop_job),
      .stat     (fifo_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // largest count a result beat may carry
   assign count_ceiling = {1'b0, cfg.loop_limit} + COUNT_W'(1);
   assign count_ok      = (rsp_chan.iteration_count != '0)
                        && (rsp_chan.iteration_count <= count_ceiling);

   // queue never holds more than its depth
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, 32'(queue_count) <= QUEUE_DEPTH, "queue overflow")
   // front end only pushes into a queue with room
   `ASSERT_IMPLY(a_push_room, clock, reset, push, !fifo_stat.full, "push into full queue")
   // iteration unit only takes a job that is there
   `ASSERT_IMPLY(a_pop_data, clock, reset, pop, !fifo_stat.empty, "pop from empty queue")
   // count lies between one and limit plus one
   `ASSERT_IMPLY(a_count_range, clock, reset, rsp_chan.valid, count_ok, "count out of range")

endmodule

### bench/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time_pixel;
   import met_pkg::*;

   // clock, run bounds and sizes used by the bench
   localparam int     HALF_PERIOD     = 6;
   localparam int     RESET_CYCLES    = 7;
   localparam int     CYCLE_LIMIT     = 3_000_000;
   localparam int     RSP_HOLD_CYCLES = 400;
   localparam int     TAIL_CYCLES     = 64;
   localparam int     IMAGE_W         = IMAGE_WIDTH_DEF;
   localparam int     IMAGE_H         = IMAGE_HEIGHT_DEF;
   localparam int     ITER_MAX        = ITER_LIMIT_DEF;
   localparam longint ESCAPE_LIMIT    = 64'sd4 <<< FRAC_BITS;

   // register slots past the last real register, writes there must be dropped
   localparam int REG_SPARE_FIRST = 5;
   localparam int REG_SPARE_LAST  = 7;

   // one expected result beat
   typedef struct {
      logic [PIXEL_W-1:0] x;
      logic [PIXEL_W-1:0] y;
      logic [COUNT_W-1:0] count;
   } pixel_result_type;

   // escape-count predictor plus the queue of counts still owed by the block
   class escape_board;
      cfg_type          cfg;
      pixel_result_type pending_pixels[$];
      int unsigned      mismatches;
      int unsigned      checked;
      int unsigned      captive;
      int unsigned      deepest;
      int unsigned      writes;

      function new();
         cfg.min_re     = MIN_RE_RST;
         cfg.max_im     = MAX_IM_RST;
         cfg.step_re    = STEP_RST;
         cfg.step_im    = STEP_RST;
         cfg.loop_limit = MAX_ITER_RST;
      endfunction

      function void set_register(int index, logic [DATA_W-1:0] value);
         writes++;
         case (index)
            REG_MIN_RE:   cfg.min_re     = value;
            REG_MAX_IM:   cfg.max_im     = value;
            REG_STEP_RE:  cfg.step_re    = value[STEP_W-1:0];
            REG_STEP_IM:  cfg.step_im    = value[STEP_W-1:0];
            REG_MAX_ITER: cfg.loop_limit = value[ITER_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [Q_W-1:0] clamp_q(longint v);
         if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
         if (v < -longint'(64'sd2147483648)) return 32'sh8000_0000;
         return v[Q_W-1:0];
      endfunction

      function logic [COUNT_W-1:0] escape_count(logic [PIXEL_W-1:0] px,
                                                logic [PIXEL_W-1:0] py);
         longint                x, y, lim, count;
         longint                zr2, zi2, zrzi;
         logic signed [Q_W-1:0] cr, ci, zr, zi;
         x   = (px > IMAGE_W - 1) ? IMAGE_W - 1 : px;
         y   = (py > IMAGE_H - 1) ? IMAGE_H - 1 : py;
         lim = (cfg.loop_limit > ITER_MAX) ? ITER_MAX : cfg.loop_limit;
         cr  = clamp_q(longint'($signed(cfg.min_re)) + x * longint'(cfg.step_re));
         ci  = clamp_q(longint'($signed(cfg.max_im)) - y * longint'(cfg.step_im));
         zr  = cr;
         zi  = ci;
         count = 1;
         forever begin
            // squares floored back to q4.28, cross term keeps the factor two
            zr2 = (longint'(zr) * longint'(zr)) >>> FRAC_BITS;
            zi2 = (longint'(zi) * longint'(zi)) >>> FRAC_BITS;
            if (zr2 + zi2 > ESCAPE_LIMIT || count > lim) break;
            zrzi = (longint'(zr) * longint'(zi)) >>> (FRAC_BITS - 1);
            zr = clamp_q(zr2 - zi2 + longint'(cr));
            zi = clamp_q(zrzi + longint'(ci));
            count++;
         end
         return COUNT_W'(count);
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
         pixel_result_type want;
         want.x     = x;
         want.y     = y;
         want.count = escape_count(x, y);
         if (want.count > cfg.loop_limit) captive++;
         if (want.count > deepest) deepest = want.count;
         pending_pixels.push_back(want);
      endfunction

      task report(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_pixel(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y,
                       logic [COUNT_W-1:0] count);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("result (%0d,%0d) count %0d with nothing pending",
                             x, y, count));
            return;
         end
         want = pending_pixels.pop_front();
         checked++;
         if (x !== want.x)
            report($sformatf("out_x %0d, expected %0d", x, want.x));
         if (y !== want.y)
            report($sformatf("out_y %0d, expected %0d", y, want.y));
         if (count !== want.count)
            report($sformatf("iteration_count %0d at (%0d,%0d), expected %0d",
                             count, want.x, want.y, want.count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   // apb side
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   met_req_if req_if ();
   met_rsp_if rsp_if ();

   escape_board board;
   int unsigned cycle_count = 0;

   // sender and receiver pacing
   bit req_steady       = 1'b0;
   bit rsp_steady       = 1'b0;
   bit hold_rsp_request = 1'b0;

   mandelbrot_escape_time_pixel dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending_pixels.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // beat monitors: note accepted pixels, check returned counts
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            board.note_pixel(req_if.pixel_x, req_if.pixel_y);
         if (rsp_if.valid && rsp_if.ready)
            board.check_pixel(rsp_if.out_x, rsp_if.out_y, rsp_if.iteration_count);
      end
   end

   // result sink: random stalls, steady stretches, and one long hold on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) rsp_steady = !rsp_steady;
         if (hold_rsp_request) begin
            // long hold so the queue fills and the block backs up its input
            hold_rsp_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(20, 60)) @(posedge clock);
            else
               repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // apb write: setup, access, wait for pready, then back to idle
   task automatic write_reg(input int index, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * index);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one pixel beat, then maybe an idle gap
   task automatic send_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      int unsigned gap;
      int unsigned pick;
      req_if.valid   <= 1'b1;
      req_if.pixel_x <= x;
      req_if.pixel_y <= y;
      do @(posedge clock); while (!req_if.ready);
      gap = 0;
      if (!req_steady) begin
         pick = $urandom_range(0, 9);
         if (pick == 9)
            gap = $urandom_range(10, 40);
         else if (pick >= 6)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 50 == 0) req_steady = ($urandom_range(0, 2) == 0);
         send_pixel(PIXEL_W'($urandom_range(0, 1023)), PIXEL_W'($urandom_range(0, 1023)));
      end
   endtask

   // block idle: input dropped, every owed count returned
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      board = new();
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_if.valid   <= 1'b0;
      req_if.pixel_x <= '0;
      req_if.pixel_y <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: whole set at limit 64, corners and known points
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd512);    // near origin, stays bounded
      send_pixel(10'd256, 10'd512);    // near -1, period-two bulb
      send_pixel(10'd384, 10'd512);    // inside main cardioid
      send_pixel(10'd767, 10'd512);    // near +1, escapes fast
      send_pixel(10'd511, 10'd255);
      send_pixel(10'd341, 10'd682);
      send_random(400);
      drain_results();

      // zoom onto the cardioid neck with a deeper limit
      write_reg(REG_MIN_RE, -32'sd214748365);
      write_reg(REG_MAX_IM, 32'sd53687091);
      write_reg(REG_STEP_RE, 32'd107374);
      write_reg(REG_STEP_IM, 32'h8001_A36E);   // top bit dropped by the 31-bit register
      write_reg(REG_MAX_ITER, 32'd255);
      send_random(200);
      drain_results();

      // limit zero: upper bits set, low 12 bits clear, no pass is run
      write_reg(REG_MAX_ITER, 32'hFFFF_F000);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd1023, 10'd0);
      send_random(100);
      drain_results();

      // limit one with the sink held off while pixels keep coming
      write_reg(REG_MAX_ITER, 32'd1);
      hold_rsp_request = 1'b1;
      send_random(100);
      drain_results();

      // writes past the last register must leave the view alone
      for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
         write_reg(i, $urandom);
      send_random(10);
      drain_results();

      // point map saturation: extreme edges with the widest pitch
      write_reg(REG_MIN_RE, 32'h8000_0000);
      write_reg(REG_MAX_IM, 32'h7FFF_FFFF);
      write_reg(REG_STEP_RE, 32'hFFFF_FFFF);
      write_reg(REG_STEP_IM, 32'h7FFF_FFFF);
      write_reg(REG_MAX_ITER, 32'd64);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1, 10'd1);
      send_pixel(10'd2, 10'd2);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd1023);
      send_random(90);
      drain_results();

      // opposite corner, zero pitch: every pixel maps to the same far point
      write_reg(REG_MIN_RE, 32'h7FFF_FFFF);
      write_reg(REG_MAX_IM, 32'h8000_0000);
      write_reg(REG_STEP_RE, 32'd0);
      write_reg(REG_STEP_IM, 32'd0);
      send_random(30);
      drain_results();

      // top limit at c = 0: never escapes, full 4096 count
      write_reg(REG_MIN_RE, 32'd0);
      write_reg(REG_MAX_IM, 32'd0);
      write_reg(REG_MAX_ITER, 32'h0000_0FFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd700, 10'd5);
      drain_results();

      // top limit over the reset view, only a handful since captive pixels are slow
      write_reg(REG_MIN_RE, MIN_RE_RST);
      write_reg(REG_MAX_IM, MAX_IM_RST);
      write_reg(REG_STEP_RE, 32'(STEP_RST));
      write_reg(REG_STEP_IM, 32'(STEP_RST));
      send_random(6);
      drain_results();

      // random views around the set, moderate limits, junk in the unused bits
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_MIN_RE, 32'(-32'sd671088640 + int'($urandom_range(0, 671088640))));
         write_reg(REG_MAX_IM, 32'($urandom_range(0, 402653184)));
         write_reg(REG_STEP_RE, {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1048576))});
         write_reg(REG_STEP_IM, {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1048576))});
         write_reg(REG_MAX_ITER, {20'($urandom), 12'($urandom_range(1, 160))});
         send_random(100);
         drain_results();
      end

      // let any stray beat show up before closing
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d pixels checked across %0d register writes in %0d cycles",
               board.checked, board.writes, cycle_count);
      $display("%0d pixels never escaped, deepest count %0d, %0d mismatches",
               board.captive, board.deepest, board.mismatches);
      if (board.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
